// File: hw/rtl/jfms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jfms_pkg;

	typedef enum logic [1:0] {
		CMD_JOY  = 2'd0,
		CMD_POSE = 2'd1,
		CMD_TRAJ = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_TAKEOFF = 3'd2,
		ACT_LAND    = 3'd3,
		ACT_GOAL    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_TAKEOFF = 2'd1,
		MODE_HOLD    = 2'd2,
		MODE_TRACK   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_MUL,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_XLO = 3'd0;
	localparam logic [2:0] REG_XHI = 3'd1;
	localparam logic [2:0] REG_YLO = 3'd2;
	localparam logic [2:0] REG_YHI = 3'd3;
	localparam logic [2:0] REG_IMS = 3'd4;
	localparam logic [2:0] REG_PG  = 3'd5;
	localparam logic [2:0] REG_YG  = 3'd6;
	localparam logic [2:0] REG_VG  = 3'd7;

	localparam logic [15:0] DB_VERT   = 16'd656;
	localparam logic [15:0] DB_PLANAR = 16'd3277;
	localparam logic [15:0] TH_PLANAR = 16'd410;
	localparam logic [15:0] TH_VERT   = 16'd41;
	localparam logic signed [15:0] HOVER_Z = 16'sd4096;
	localparam logic [31:0] T_MIN = 32'd4096;
	localparam logic [31:0] T_MAX = 32'd40960;

	typedef struct packed {
		logic [1:0]         command;
		logic [3:0]         buttons;
		logic signed [15:0] axis_yaw;
		logic signed [15:0] axis_vertical;
		logic signed [15:0] axis_lateral;
		logic signed [15:0] axis_forward;
		logic signed [15:0] pose_x;
		logic signed [15:0] pose_y;
		logic signed [15:0] pose_z;
		logic signed [15:0] pose_yaw;
		logic               traj_done;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         action;
		logic               out_of_box;
		logic [15:0]        travel_time;
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
		logic signed [15:0] goal_z;
		logic signed [15:0] goal_yaw;
	} out_item_t;

	// control between sequencer and travel-time unit
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} tt_ctl_t;

	function automatic logic signed [15:0] clamp_box(input logic signed [16:0] v,
		input logic signed [15:0] hi, input logic signed [15:0] lo);
		logic signed [15:0] r;
		if (v > 17'(hi)) r = hi;
		else if (v < 17'(lo)) r = lo;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/joystick_flight_mode_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Flight-mode sequencer for a hovering vehicle.
// Input channel in_valid/in_ready carries one request of type in_item_t:
// joystick events, pose updates and trajectory flags change state only; a
// loop tick yields exactly one result on out_valid/out_ready.
// A tick without a trajectory shows its result in the cycle after acceptance,
// through the output register.
// A joystick move in tracking mode holds in_ready low while the 12-bit serial
// gain multiplier works through its axes: vertical alone, or forward, lateral, yaw for planar.
// Takeoff and land ticks run the travel-time unit: three 17x17 squares and a
// 17x17 product on one bit-serial multiplier and an 18-step integer root; the
// result then passes the done phase and ST_OUT into the output register.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle,
// legal only while idle; the 3-bit index selects one of eight registers.
// Reset (arst_n low) restores register defaults, mode idle, done flag set,
// pose and offsets zero. While the receiver stalls a result is held in the
// output register and in_ready stays low until the result is taken.
module joystick_flight_mode_sequencer_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire jfms_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output jfms_pkg::out_item_t       out_data,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [15:0]          cfg_data
);
	logic signed [15:0] xlo_q, xhi_q, ylo_q, yhi_q;
	logic [15:0] ims_q;
	logic [11:0] pg_q, yg_q, vg_q;

	jfms_pkg::mode_t mode_q;
	logic fly_q, trk_q, done_q;
	logic signed [15:0] pos_q [4];
	logic signed [15:0] off_q [4];

	jfms_pkg::state_t st_q, st_d;
	jfms_pkg::out_item_t res_q;
	logic ovalid_q;
	logic [2:0] pend_act_q;
	logic pend_oob_q;

	// offset computation: one axis at a time on the serial multiplier
	logic [1:0] ax_q;
	logic joy_busy_q;
	logic [15:0] amag;
	logic [11:0] again;
	logic [15:0] adb;
	logic signed [15:0] araw;
	logic gm_start, gm_done;
	logic [27:0] gm_prod;
	logic joy_accept, tick_accept, in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlo_q <= -16'sd4096; xhi_q <= 16'sd4096;
			ylo_q <= -16'sd6144; yhi_q <= 16'sd6144;
			ims_q <= 16'd20480; pg_q <= 12'd819; yg_q <= 12'd1229; vg_q <= 12'd410;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jfms_pkg::REG_XLO: xlo_q <= cfg_data;
				jfms_pkg::REG_XHI: xhi_q <= cfg_data;
				jfms_pkg::REG_YLO: ylo_q <= cfg_data;
				jfms_pkg::REG_YHI: yhi_q <= cfg_data;
				jfms_pkg::REG_IMS: ims_q <= cfg_data;
				jfms_pkg::REG_PG:  pg_q  <= cfg_data[11:0];
				jfms_pkg::REG_YG:  yg_q  <= cfg_data[11:0];
				jfms_pkg::REG_VG:  vg_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// travel-time unit
	jfms_pkg::tt_ctl_t tt_ctl;
	logic tt_start;
	logic [15:0] tt_val;
	logic signed [15:0] tdx, tdy;
	logic signed [16:0] tdz;
	logic tt_is_land_q;

	assign tdx = pos_q[0];
	assign tdy = pos_q[1];
	assign tdz = tt_is_land_q ? 17'(pos_q[2]) : 17'(jfms_pkg::HOVER_Z) - 17'(pos_q[2]);

	jfms_travel u_travel (
		.clk(clk), .arst_n(arst_n), .start(tt_start), .dx(tdx), .dy(tdy), .dz(tdz),
		.inv_speed(ims_q), .ctl(tt_ctl), .ttime(tt_val)
	);

	assign in_ready = (st_q == jfms_pkg::ST_IDLE) && !joy_busy_q && !tt_ctl.busy
		&& !ovalid_q;
	assign in_acc = in_valid && in_ready;
	assign joy_accept = in_acc && (in_data.command == jfms_pkg::CMD_JOY);
	assign tick_accept = in_acc && (in_data.command == jfms_pkg::CMD_TICK);

	// latched joystick request
	logic signed [15:0] jax_q [4];
	logic [3:0] jsel_q;
	always_comb begin
		unique case (ax_q)
			2'd0: begin araw = jax_q[0]; again = pg_q; adb = jfms_pkg::DB_PLANAR; end
			2'd1: begin araw = jax_q[1]; again = pg_q; adb = jfms_pkg::DB_PLANAR; end
			2'd2: begin araw = jax_q[2]; again = vg_q; adb = jfms_pkg::DB_VERT; end
			default: begin araw = jax_q[3]; again = yg_q; adb = jfms_pkg::DB_PLANAR; end
		endcase
		amag = jfms_pkg::mag16(araw);
	end

	logic gm_first_q;
	assign gm_start = gm_first_q;
	jfms_serial_mul #(.AW(16), .BW(12)) u_gain (
		.clk(clk), .arst_n(arst_n), .start(gm_start), .a(amag), .b(again),
		.done(gm_done), .prod(gm_prod)
	);
	logic [15:0] scaled;
	logic signed [15:0] sres;
	// Q1.27 product down to Q4.12, at most 13 bits
	assign scaled = {3'b000, gm_prod[27:15]};
	always_comb begin
		if (amag < adb) sres = '0;
		else sres = araw[15] ? 16'(-scaled) : scaled;
	end

	// tick evaluation
	logic oob;
	logic [15:0] om [4];
	logic go;
	assign oob = pos_q[0] > xhi_q || pos_q[0] < xlo_q || pos_q[1] > yhi_q || pos_q[1] < ylo_q;
	always_comb begin
		for (int i = 0; i < 4; i++) om[i] = jfms_pkg::mag16(off_q[i]);
	end
	assign go = om[0] >= jfms_pkg::TH_PLANAR || om[1] >= jfms_pkg::TH_PLANAR
		|| om[2] >= jfms_pkg::TH_VERT || om[3] >= jfms_pkg::TH_PLANAR;

	logic signed [16:0] s0, s1, s2, s3;
	assign s0 = 17'(pos_q[0]) + 17'(off_q[0]);
	assign s1 = 17'(pos_q[1]) + 17'(off_q[1]);
	assign s2 = 17'(pos_q[2]) + 17'(off_q[2]);
	assign s3 = 17'(pos_q[3]) + 17'(off_q[3]);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			jfms_pkg::ST_IDLE: if (tt_start) st_d = jfms_pkg::ST_ROOT;
			jfms_pkg::ST_ROOT: if (tt_ctl.done) st_d = jfms_pkg::ST_OUT;
			jfms_pkg::ST_OUT: st_d = jfms_pkg::ST_IDLE;
			default: st_d = jfms_pkg::ST_IDLE;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= jfms_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	logic tick_trav;
	assign tick_trav = tick_accept && done_q && (mode_q == jfms_pkg::MODE_TAKEOFF
		|| (mode_q == jfms_pkg::MODE_HOLD && !fly_q));
	assign tt_start = tick_trav;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jfms_pkg::MODE_IDLE;
			fly_q <= 1'b0; trk_q <= 1'b0; done_q <= 1'b1;
			for (int i = 0; i < 4; i++) begin pos_q[i] <= '0; off_q[i] <= '0; end
			ovalid_q <= 1'b0; joy_busy_q <= 1'b0; gm_first_q <= 1'b0;
			ax_q <= 2'd0; tt_is_land_q <= 1'b0;
		end else begin
			gm_first_q <= 1'b0;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (in_acc) begin
				unique case (in_data.command)
					jfms_pkg::CMD_JOY: begin
						if (in_data.buttons[0] && (mode_q == jfms_pkg::MODE_HOLD
							|| mode_q == jfms_pkg::MODE_TRACK)) trk_q <= !trk_q;
						else if (in_data.buttons[1] && (mode_q == jfms_pkg::MODE_IDLE
							|| mode_q == jfms_pkg::MODE_HOLD)) fly_q <= !fly_q;
						else if (mode_q == jfms_pkg::MODE_TRACK) begin
							for (int i = 0; i < 4; i++) off_q[i] <= '0;
							if (in_data.buttons[3]) begin
								joy_busy_q <= 1'b1; ax_q <= 2'd2; gm_first_q <= 1'b1;
							end else if (in_data.buttons[2]) begin
								joy_busy_q <= 1'b1; ax_q <= 2'd0; gm_first_q <= 1'b1;
							end
						end
					end
					jfms_pkg::CMD_POSE: begin
						pos_q[0] <= in_data.pose_x; pos_q[1] <= in_data.pose_y;
						pos_q[2] <= in_data.pose_z; pos_q[3] <= in_data.pose_yaw;
					end
					jfms_pkg::CMD_TRAJ: done_q <= in_data.traj_done;
					default: begin
						res_q.out_of_box <= oob;
						res_q.travel_time <= '0;
						res_q.action <= jfms_pkg::ACT_NONE;
						res_q.goal_x <= '0; res_q.goal_y <= '0;
						res_q.goal_z <= '0; res_q.goal_yaw <= '0;
						unique case (mode_q)
							jfms_pkg::MODE_IDLE: begin
								if (fly_q && done_q) begin
									res_q.action <= jfms_pkg::ACT_START;
									mode_q <= jfms_pkg::MODE_TAKEOFF;
								end
								ovalid_q <= 1'b1;
							end
							jfms_pkg::MODE_TAKEOFF: begin
								if (done_q) begin
									tt_is_land_q <= 1'b0;
									pend_act_q <= jfms_pkg::ACT_TAKEOFF;
									pend_oob_q <= oob;
									done_q <= 1'b0; mode_q <= jfms_pkg::MODE_HOLD;
								end else ovalid_q <= 1'b1;
							end
							jfms_pkg::MODE_HOLD: begin
								if (done_q && !fly_q) begin
									tt_is_land_q <= 1'b1;
									pend_act_q <= jfms_pkg::ACT_LAND;
									pend_oob_q <= oob;
									done_q <= 1'b0; mode_q <= jfms_pkg::MODE_IDLE;
								end else begin
									if (trk_q && done_q) mode_q <= jfms_pkg::MODE_TRACK;
									ovalid_q <= 1'b1;
								end
							end
							default: begin
								if (done_q && go) begin
									res_q.action <= jfms_pkg::ACT_GOAL;
									res_q.goal_x <= jfms_pkg::clamp_box(s0, xhi_q, xlo_q);
									res_q.goal_y <= jfms_pkg::clamp_box(s1, yhi_q, ylo_q);
									res_q.goal_z <= jfms_pkg::clamp_box(s2, 16'sh7fff,
										-16'sh8000);
									res_q.goal_yaw <= jfms_pkg::clamp_box(s3, 16'sh7fff,
										-16'sh8000);
								end
								if (!trk_q) mode_q <= jfms_pkg::MODE_HOLD;
								ovalid_q <= 1'b1;
							end
						endcase
					end
				endcase
			end
			if (joy_accept) begin
				jax_q[0] <= in_data.axis_forward; jax_q[1] <= in_data.axis_lateral;
				jax_q[2] <= in_data.axis_vertical; jax_q[3] <= in_data.axis_yaw;
			end
			// planar move walks forward, lateral, yaw; vertical move is one axis
			if (joy_busy_q && gm_done) begin
				off_q[ax_q] <= sres;
				if (ax_q == 2'd0) begin
					ax_q <= 2'd1; gm_first_q <= 1'b1;
				end else if (ax_q == 2'd1) begin
					ax_q <= 2'd3; gm_first_q <= 1'b1;
				end else joy_busy_q <= 1'b0;
			end
			if (st_q == jfms_pkg::ST_OUT) begin
				res_q.action <= pend_act_q;
				res_q.out_of_box <= pend_oob_q;
				res_q.travel_time <= tt_val;
				res_q.goal_x <= '0; res_q.goal_y <= '0;
				res_q.goal_z <= (pend_act_q == jfms_pkg::ACT_TAKEOFF) ? jfms_pkg::HOVER_Z : '0;
				res_q.goal_yaw <= '0;
				ovalid_q <= 1'b1;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_data = res_q;

	ast_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tt_ctl.busy |-> !in_ready) else $error("request taken during travel computation");
	ast_result_after_travel: assert property (@(posedge clk) disable iff (!arst_n)
		tt_ctl.done |-> ##2 out_valid) else $error("travel result not presented");
	ast_held_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: hw/rtl/jfms_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
module jfms_serial_mul #(
	parameter int AW = 16,
	parameter int BW = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [AW-1:0]       a,
	input  wire logic [BW-1:0]       b,
	output logic                     done,
	output logic [AW+BW-1:0]         prod
);
	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] acc_q;
	logic [AW+BW-1:0] mcand_q;
	logic [BW-1:0]    mplier_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(BW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= (AW+BW)'(a);
			mplier_q <= b;
		end else if (run_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = run_q && (cnt_q == CW'(1));
	assign prod = mplier_q[0] ? acc_q + mcand_q : acc_q;
endmodule
`default_nettype wire

// File: hw/rtl/jfms_travel.sv
`timescale 1ns / 1ps
`default_nettype none
// Travel time: squares by a serial multiplier, bitwise integer root, serial
// product with inverse speed, then clamp to one..ten seconds.
module jfms_travel (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] dx,
	input  wire logic signed [15:0] dy,
	input  wire logic signed [16:0] dz,
	input  wire logic [15:0]        inv_speed,
	output jfms_pkg::tt_ctl_t       ctl,
	output logic [15:0]             ttime
);
	typedef enum logic [2:0] {P_IDLE, P_SQ, P_ROOT, P_MUL, P_DONE} phase_t;

	phase_t      ph_q;
	logic [1:0]  sq_idx_q;
	logic [35:0] sum_q;
	logic [35:0] rem_q;
	logic [35:0] root_q;
	logic [35:0] bit_q;
	logic [15:0] tt_q;
	logic        mstart;
	logic        mdone;
	logic [16:0] ma;
	logic [16:0] mb;
	logic [33:0] mprod;
	logic [16:0] mag_sel;
	logic        first_q;

	always_comb begin
		unique case (sq_idx_q)
			2'd0: mag_sel = dx[15] ? 17'(-17'(dx)) : 17'(dx);
			2'd1: mag_sel = dy[15] ? 17'(-17'(dy)) : 17'(dy);
			default: mag_sel = dz[16] ? 17'(-dz) : 17'(dz);
		endcase
	end

	assign ma = (ph_q == P_MUL) ? root_q[16:0] : mag_sel;
	assign mb = (ph_q == P_MUL) ? 17'(inv_speed) : mag_sel;
	assign mstart = first_q;

	jfms_serial_mul #(.AW(17), .BW(17)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.done(mdone), .prod(mprod)
	);

	logic [35:0] trial;
	logic [35:0] tprod;
	assign trial = root_q + bit_q;
	assign tprod = 36'(mprod) >> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= P_IDLE;
			first_q  <= 1'b0;
			sq_idx_q <= 2'd0;
		end else begin
			first_q <= 1'b0;
			unique case (ph_q)
				P_IDLE: if (start) begin
					ph_q <= P_SQ; sq_idx_q <= 2'd0; first_q <= 1'b1;
				end
				P_SQ: if (mdone) begin
					if (sq_idx_q == 2'd2) ph_q <= P_ROOT;
					else begin
						sq_idx_q <= sq_idx_q + 2'd1; first_q <= 1'b1;
					end
				end
				P_ROOT: if (bit_q == '0) begin
					ph_q <= P_MUL; first_q <= 1'b1;
				end
				P_MUL: if (mdone) ph_q <= P_DONE;
				P_DONE: ph_q <= P_IDLE;
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == P_IDLE && start) sum_q <= '0;
		if (ph_q == P_SQ && mdone) begin
			sum_q <= sum_q + 36'(mprod);
			if (sq_idx_q == 2'd2) begin
				rem_q  <= sum_q + 36'(mprod);
				root_q <= '0;
				bit_q  <= 36'h4_0000_0000;
			end
		end
		if (ph_q == P_ROOT && bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (ph_q == P_MUL && mdone) begin
			if (tprod < 36'(jfms_pkg::T_MIN)) tt_q <= 16'(jfms_pkg::T_MIN);
			else if (tprod > 36'(jfms_pkg::T_MAX)) tt_q <= 16'(jfms_pkg::T_MAX);
			else tt_q <= tprod[15:0];
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = (ph_q != P_IDLE);
	assign ctl.done  = (ph_q == P_DONE);
	assign ttime     = tt_q;
endmodule
`default_nettype wire
